// ===== rtl/psrt_pkg.sv =====
// Shared widths, codes, types and helpers of the probe reach test
`default_nettype none
package psrt_pkg;
	localparam int CW    = 20;
	localparam int RW    = CW - 1;
	localparam int SQW   = 2 * CW;
	localparam int DW    = 2 * CW + 2;
	localparam int KW    = 15;
	localparam int K2W   = 2 * KW;
	localparam int MW    = (SQW > K2W) ? SQW : K2W;
	localparam int HW    = MW / 2;
	localparam int PW    = 2 * MW;
	localparam int WW    = 3 * MW;
	localparam int IDXW  = 3;
	localparam int DATAW = (CW > KW) ? CW : KW;
	localparam int LAT   = 9;

	localparam logic signed [CW-1:0] CX_RST = CW'(0);
	localparam logic signed [CW-1:0] CY_RST = CW'(20800);
	localparam logic [RW-1:0]        R_RST  = RW'(20800);
	localparam logic [RW-1:0]        RI_RST = RW'(5760);
	localparam logic [RW-1:0]        RO_RST = RW'(9619);
	localparam logic [KW-1:0]        K_RST  = KW'(28378);

	typedef enum logic [IDXW-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_REACH,
		REG_INNER,
		REG_OUTER,
		REG_SWEEP
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FAIL_NONE,
		FAIL_CROSS,
		FAIL_REACH,
		FAIL_ANNULUS,
		FAIL_SWEEP
	} fail_t;

	typedef struct packed {
		logic signed [CW-1:0] star_x;
		logic signed [CW-1:0] star_y;
	} star_t;

	typedef struct packed {
		logic       reachable;
		logic [2:0] fail_reason;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [RW-1:0]        r;
		logic [SQW-1:0]       r2;
		logic [SQW-1:0]       c2;
		logic [SQW-1:0]       in2;
		logic [SQW-1:0]       out2;
		logic [K2W-1:0]       k2;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic                 ge;
		logic [SQW-1:0]       t;
		logic [SQW-1:0]       s2;
		logic [DW-1:0]        u2;
		logic signed [DW-1:0] dot;
		logic                 ann;
		logic                 axis;
	} geo_t;

	function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
		return v[CW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [CW:0] mag_d(input logic signed [CW:0] v);
		return v[CW] ? (~v + 1'b1) : v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/psrt_cfg.sv =====
// Configuration registers and the squares derived from them
`default_nettype none
module psrt_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [psrt_pkg::IDXW-1:0]    wr_index,
	input  logic [psrt_pkg::DATAW-1:0]   wr_data,
	output psrt_pkg::cfg_t               cfg
);
	import psrt_pkg::*;

	logic signed [CW-1:0] cx_q, cy_q;
	logic [RW-1:0]        r_q, ri_q, ro_q;
	logic [KW-1:0]        k_q;
	logic [SQW-1:0]       r2_q, c2_q, in2_q, out2_q;
	logic [K2W-1:0]       k2_q;
	logic [CW-1:0]        mcx, mcy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= CX_RST;
			cy_q <= CY_RST;
			r_q  <= R_RST;
			ri_q <= RI_RST;
			ro_q <= RO_RST;
			k_q  <= K_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X: cx_q <= wr_data[CW-1:0];
				REG_CENTER_Y: cy_q <= wr_data[CW-1:0];
				REG_REACH:    r_q  <= wr_data[RW-1:0];
				REG_INNER:    ri_q <= wr_data[RW-1:0];
				REG_OUTER:    ro_q <= wr_data[RW-1:0];
				REG_SWEEP:    k_q  <= wr_data[KW-1:0];
				default: ;
			endcase
		end
	end

	assign mcx = mag_c(cx_q);
	assign mcy = mag_c(cy_q);

	// registered, so they follow a register write in the next cycle; items read these from their third stage on
	always_ff @(posedge clk) begin
		r2_q   <= SQW'(r_q) * SQW'(r_q);
		c2_q   <= SQW'(mcx) * SQW'(mcx) + SQW'(mcy) * SQW'(mcy);
		in2_q  <= SQW'(ri_q) * SQW'(ri_q);
		out2_q <= SQW'(ro_q) * SQW'(ro_q);
		k2_q   <= K2W'(k_q) * K2W'(k_q);
	end

	assign cfg = '{cx: cx_q, cy: cy_q, r: r_q, r2: r2_q, c2: c2_q,
		in2: in2_q, out2: out2_q, k2: k2_q};
endmodule
`default_nettype wire

// ===== rtl/psrt_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products
`default_nettype none
module psrt_mul (
	input  logic                    clk,
	input  logic [psrt_pkg::MW-1:0] a,
	input  logic [psrt_pkg::MW-1:0] b,
	output logic [psrt_pkg::PW-1:0] p
);
	import psrt_pkg::*;

	logic [MW-1:0] pll_s1, plh_s1, phl_s1, phh_s1;
	logic [PW-1:0] p_s2;

	always_ff @(posedge clk) begin
		pll_s1 <= MW'(a[HW-1:0])  * MW'(b[HW-1:0]);
		plh_s1 <= MW'(a[HW-1:0])  * MW'(b[MW-1:HW]);
		phl_s1 <= MW'(a[MW-1:HW]) * MW'(b[HW-1:0]);
		phh_s1 <= MW'(a[MW-1:HW]) * MW'(b[MW-1:HW]);
		p_s2   <= {phh_s1, pll_s1} + (PW'(plh_s1) << HW) + (PW'(phl_s1) << HW);
	end

	assign p = p_s2;
endmodule
`default_nettype wire

// ===== rtl/psrt_geom.sv =====
// Front stages: squares, offsets from the centre, dot terms and early compares
`default_nettype none
module psrt_geom (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  psrt_pkg::star_t star,
	input  psrt_pkg::cfg_t  cfg,
	output psrt_pkg::geo_t  geo
);
	import psrt_pkg::*;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [CW-1:0] sx_s1, sy_s1;
	logic [SQW-1:0]       sqx_s2, sqy_s2;
	logic signed [CW:0]   dx_s2, dy_s2;
	logic [SQW-1:0]       s2_s3;
	logic [DW-1:0]        dx2_s3, dy2_s3;
	logic signed [DW-1:0] dtx_s3, dty_s3;
	logic                 axis_s3;
	logic                 ge_s4, ann_s4, axis_s4;
	logic [SQW-1:0]       t_s4, s2_s4;
	logic [DW-1:0]        u2_s4;
	logic signed [DW-1:0] dot_s4;
	logic [CW-1:0]        msx, msy;
	logic [CW:0]          mdx, mdy;
	logic signed [CW:0]   ncx, ncy;
	logic [DW-1:0]        diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign msx = mag_c(sx_s1);
	assign msy = mag_c(sy_s1);
	assign mdx = mag_d(dx_s2);
	assign mdy = mag_d(dy_s2);
	assign ncx = -((CW+1)'(cfg.cx));
	assign ncy = -((CW+1)'(cfg.cy));

	// c2 - r2 - s2: sign says whether the crossing test needs the squared compare
	assign diff = DW'(cfg.c2) - DW'(cfg.r2) - DW'(s2_s3);

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sx_s1 <= star.star_x;
			sy_s1 <= star.star_y;
		end
		sqx_s2  <= SQW'(msx) * SQW'(msx);
		sqy_s2  <= SQW'(msy) * SQW'(msy);
		dx_s2   <= (CW+1)'(sx_s1) - (CW+1)'(cfg.cx);
		dy_s2   <= (CW+1)'(sy_s1) - (CW+1)'(cfg.cy);
		s2_s3   <= sqx_s2 + sqy_s2;
		dx2_s3  <= DW'(mdx) * DW'(mdx);
		dy2_s3  <= DW'(mdy) * DW'(mdy);
		dtx_s3  <= DW'(dx_s2) * DW'(ncx);
		dty_s3  <= DW'(dy_s2) * DW'(ncy);
		axis_s3 <= (mdx <= (CW+1)'(cfg.r)) && (mdy <= (CW+1)'(cfg.r));
		ge_s4   <= !diff[DW-1];
		t_s4    <= diff[SQW-1:0];
		s2_s4   <= s2_s3;
		u2_s4   <= dx2_s3 + dy2_s3;
		dot_s4  <= dtx_s3 + dty_s3;
		ann_s4  <= (cfg.in2 < s2_s3) && (s2_s3 < cfg.out2);
		axis_s4 <= axis_s3;
	end

	assign geo = '{valid: v_s4, ge: ge_s4, t: t_s4, s2: s2_s4, u2: u2_s4,
		dot: dot_s4, ann: ann_s4, axis: axis_s4};
endmodule
`default_nettype wire

// ===== rtl/probe_star_reach_test.sv =====
// Top level of the probe reach test: config, front stages, wide products, verdict
//
//  channel   signals                                   word
//  star in   start, busy, star                         star_x, star_y
//  result    done, result                              reachable, fail_reason
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// One star is taken every cycle while busy is low; its result word comes out with done
// after the star has passed through the whole pipeline.
// That path runs through four front stages, two chained split multipliers
// (the sweep product needs a second multiply on the first one's output) and the output register.
// After reset release busy stays high and cfg_ready low until the ready register is set.
// Nothing ever stalls: done is a one-cycle strobe the receiver must take.
`default_nettype none
module probe_star_reach_test (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  psrt_pkg::star_t            star,
	output logic                       done,
	output psrt_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [psrt_pkg::IDXW-1:0]  cfg_index,
	input  logic [psrt_pkg::DATAW-1:0] cfg_data
);
	import psrt_pkg::*;

	logic          rdy_q;
	cfg_t          cfg;
	geo_t          geo;
	fail_t         rsn4, rsn6, rsn_fin;
	fail_t         rsn_s5, rsn_s6, rsn_s7, rsn_s8;
	logic          v_s5, v_s6, v_s7, v_s8, v_s9;
	logic          ge_s5, ge_s6;
	logic          crs_fail, sweep_ok;
	logic [PW-1:0] tt, rs, uc, dd, kl, kh;
	logic [PW-1:0] dd_s7, dd_s8;
	logic [WW-1:0] lhs, rhs;
	result_t       res_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
		end
	end

	assign busy      = !rdy_q;
	assign cfg_ready = rdy_q;

	psrt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	psrt_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.star     (star),
		.cfg      (cfg),
		.geo      (geo)
	);

	// later tests only matter once the earlier ones pass
	always_comb begin
		priority if (!(geo.axis && (geo.u2 <= DW'(cfg.r2)))) begin
			rsn4 = FAIL_REACH;
		end else if (!geo.ann) begin
			rsn4 = FAIL_ANNULUS;
		end else if (geo.dot[DW-1] || (geo.dot == '0)) begin
			rsn4 = FAIL_SWEEP;
		end else begin
			rsn4 = FAIL_NONE;
		end
	end

	psrt_mul u_mul_tt (.clk(clk), .a(MW'(geo.t)), .b(MW'(geo.t)), .p(tt));
	psrt_mul u_mul_rs (.clk(clk), .a(MW'(cfg.r2)), .b(MW'(geo.s2)), .p(rs));
	psrt_mul u_mul_uc (.clk(clk), .a(MW'(geo.u2[SQW-1:0])), .b(MW'(cfg.c2)), .p(uc));
	psrt_mul u_mul_dd (.clk(clk), .a(MW'(geo.dot[SQW-1:0])),
		.b(MW'(geo.dot[SQW-1:0])), .p(dd));
	psrt_mul u_mul_kl (.clk(clk), .a(MW'(cfg.k2)), .b(uc[MW-1:0]), .p(kl));
	psrt_mul u_mul_kh (.clk(clk), .a(MW'(cfg.k2)), .b(uc[PW-1:MW]), .p(kh));

	// circles fail to cross when (c2 - r2 - s2)^2 >= 4 r2 s2 with c2 >= r2 + s2
	assign crs_fail = ge_s6 && ({2'b00, tt} >= {rs, 2'b00});
	assign rsn6     = crs_fail ? FAIL_CROSS : rsn_s6;

	// dot^2 * 2^30 against K^2 * u2 * c2
	assign lhs      = WW'(dd_s8) << K2W;
	assign rhs      = (WW'(kh) << MW) + WW'(kl);
	assign sweep_ok = lhs > rhs;
	assign rsn_fin  = ((rsn_s8 == FAIL_NONE) && !sweep_ok) ? FAIL_SWEEP : rsn_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s5 <= geo.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		rsn_s5 <= rsn4;
		ge_s5  <= geo.ge;
		rsn_s6 <= rsn_s5;
		ge_s6  <= ge_s5;
		rsn_s7 <= rsn6;
		dd_s7  <= dd;
		rsn_s8 <= rsn_s7;
		dd_s8  <= dd_s7;
		res_s9 <= '{reachable: (rsn_fin == FAIL_NONE), fail_reason: rsn_fin};
	end

	assign done   = v_s9;
	assign result = res_s9;
endmodule
`default_nettype wire

// ===== rtl/psrt_chk.sv =====
// Port-level checks of the probe reach test and their binding to the top level
`default_nettype none
module psrt_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input psrt_pkg::result_t result
);
	import psrt_pkg::*;

	// every accepted star yields its result word on done
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted star produced no result");

	// no result word without a matching accepted star
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without a matching star");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.reachable == (result.fail_reason == FAIL_NONE)))
		else $error("reachable flag disagrees with fail reason");

	// once out of reset the block never refuses a star
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after reset");
endmodule

bind probe_star_reach_test psrt_chk u_psrt_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
